@@ rtl/core/gnfp_pkg.sv @@
// ----------------------------------------------------------------------------
// Gradient norm floor penalty: shared constants
// Widths and stage counts used by the core and its pipelined arithmetic units.
// ----------------------------------------------------------------------------
package gnfp_pkg;

  localparam int FACE_TAG_BITS_DEF = 20;

  localparam int ROOT_W      = 64;
  localparam int RAD_W       = 2 * ROOT_W;
  localparam int SQRT_STAGES = ROOT_W;

  localparam int NUM_W      = 128;
  localparam int DEN_W      = 64;
  localparam int QUO_W      = 64;
  localparam int DIV_STAGES = NUM_W;
  localparam int DIV_LANES  = 2;

  localparam int IN_FIXED_W  = 287;
  localparam int OUT_FIXED_W = 191;

endpackage

@@ rtl/core/gnfp_sqrt.sv @@
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage; the root is floor(sqrt(radicand)). A side vector
// travels with each beat.
// ----------------------------------------------------------------------------
module gnfp_sqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [gnfp_pkg::RAD_W-1:0]   in_rad,
  input  logic [SIDE_W-1:0]            in_side,
  output logic                         out_valid,
  output logic [gnfp_pkg::ROOT_W-1:0]  out_root,
  output logic [SIDE_W-1:0]            out_side
);

  localparam int N  = gnfp_pkg::SQRT_STAGES;
  localparam int RW = gnfp_pkg::ROOT_W;
  localparam int XW = gnfp_pkg::RAD_W;

  logic              v_r    [N];
  logic [RW:0]       rem_r  [N];
  logic [RW-1:0]     root_r [N];
  logic [XW-1:0]     x_r    [N];
  logic [SIDE_W-1:0] side_r [N];

  for (genvar j = 0; j < N; j++) begin : g_st
    logic              v_c;
    logic [RW:0]       rem_c;
    logic [RW-1:0]     root_c;
    logic [XW-1:0]     x_c;
    logic [SIDE_W-1:0] side_c;
    logic [RW+2:0]     r2;
    logic [RW+2:0]     trial;

    if (j == 0) begin : g_first
      assign v_c    = in_valid;
      assign rem_c  = '0;
      assign root_c = '0;
      assign x_c    = in_rad;
      assign side_c = in_side;
    end else begin : g_next
      assign v_c    = v_r[j-1];
      assign rem_c  = rem_r[j-1];
      assign root_c = root_r[j-1];
      assign x_c    = x_r[j-1];
      assign side_c = side_r[j-1];
    end

    assign r2    = {rem_c, x_c[XW-1:XW-2]};
    assign trial = {1'b0, root_c, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[j]    <= {x_c[XW-3:0], 2'b00};
        side_r[j] <= side_c;
        if (r2 >= trial) begin
          rem_r[j]  <= (RW+1)'(r2 - trial);
          root_r[j] <= {root_c[RW-2:0], 1'b1};
        end else begin
          rem_r[j]  <= r2[RW:0];
          root_r[j] <= {root_c[RW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_root  = root_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

@@ rtl/core/gnfp_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined two-lane restoring divider
// Both lanes share one divisor; one numerator bit per stage, and the low
// quotient bits are kept. A side vector travels with each beat.
// ----------------------------------------------------------------------------
module gnfp_div #(
  parameter int SIDE_W = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [gnfp_pkg::NUM_W-1:0]   in_num [gnfp_pkg::DIV_LANES],
  input  logic [gnfp_pkg::DEN_W-1:0]   in_den,
  input  logic [SIDE_W-1:0]            in_side,
  output logic                         out_valid,
  output logic [gnfp_pkg::QUO_W-1:0]   out_quo [gnfp_pkg::DIV_LANES],
  output logic [SIDE_W-1:0]            out_side
);

  localparam int N  = gnfp_pkg::DIV_STAGES;
  localparam int L  = gnfp_pkg::DIV_LANES;
  localparam int NW = gnfp_pkg::NUM_W;
  localparam int DW = gnfp_pkg::DEN_W;
  localparam int QW = gnfp_pkg::QUO_W;

  logic              v_r    [N];
  logic [DW-1:0]     den_r  [N];
  logic [SIDE_W-1:0] side_r [N];
  logic [DW-1:0]     rem_r  [N][L];
  logic [NW-1:0]     num_r  [N][L];
  logic [QW-1:0]     quo_r  [N][L];

  for (genvar j = 0; j < N; j++) begin : g_st
    logic              v_c;
    logic [DW-1:0]     den_c;
    logic [SIDE_W-1:0] side_c;

    if (j == 0) begin : g_first
      assign v_c    = in_valid;
      assign den_c  = in_den;
      assign side_c = in_side;
    end else begin : g_next
      assign v_c    = v_r[j-1];
      assign den_c  = den_r[j-1];
      assign side_c = side_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[j]  <= den_c;
        side_r[j] <= side_c;
      end
    end

    for (genvar k = 0; k < L; k++) begin : g_lane
      logic [DW-1:0] rem_c;
      logic [NW-1:0] num_c;
      logic [QW-1:0] quo_c;
      logic [DW:0]   r_sh;

      if (j == 0) begin : g_first
        assign rem_c = '0;
        assign num_c = in_num[k];
        assign quo_c = '0;
      end else begin : g_next
        assign rem_c = rem_r[j-1][k];
        assign num_c = num_r[j-1][k];
        assign quo_c = quo_r[j-1][k];
      end

      assign r_sh = {rem_c, num_c[NW-1]};

      always_ff @(posedge clk) begin
        if (en) begin
          num_r[j][k] <= {num_c[NW-2:0], 1'b0};
          if (r_sh >= {1'b0, den_c}) begin
            rem_r[j][k] <= DW'(r_sh - {1'b0, den_c});
            quo_r[j][k] <= {quo_c[QW-2:0], 1'b1};
          end else begin
            rem_r[j][k] <= r_sh[DW-1:0];
            quo_r[j][k] <= {quo_c[QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_side  = side_r[N-1];
  for (genvar k = 0; k < L; k++) begin : g_out
    assign out_quo[k] = quo_r[N-1][k];
  end

endmodule

@@ rtl/core/gradient_norm_floor_penalty_core.sv @@
// ----------------------------------------------------------------------------
// Gradient norm floor penalty core
// Per-face penalty on the norm of g = M*d when it falls below a floor.
// ----------------------------------------------------------------------------
// One beat on the in_ stream carries one face: the 3x2 matrix, the two phase
// increments, the minimum edge length and the face tag. One beat on the out_
// stream carries its energy and two derivatives in Q32.32, the tag, and in
// out_tuser the below-floor and saturation flags.
// The user writes the threshold register through cfg_wr_en/cfg_wr_data only
// while no face is in flight; the block does not enforce this. Reset clears
// it, which keeps every face above the floor. Stages: five product and sum,
// 64 square root, one floor compare, 128 divider stages for the two derivative
// quotients and three stages for the final products and clamping. The whole
// pipeline accepts one face per cycle while the output is not stalled.
// When the receiver stalls with a result waiting, every stage holds and
// in_tready drops in the same cycle; nothing is lost or repeated.
// Reset empties the pipeline and lowers out_tvalid.
// ----------------------------------------------------------------------------
module gradient_norm_floor_penalty_core #(
  parameter int FACE_TAG_BITS = gnfp_pkg::FACE_TAG_BITS_DEF,
  localparam int IN_W  = ((gnfp_pkg::IN_FIXED_W + FACE_TAG_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((gnfp_pkg::OUT_FIXED_W + FACE_TAG_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [31:0]      cfg_wr_data,
  input  logic             in_tvalid,
  output logic             in_tready,
  // m_row0_col0, m_row1_col0, m_row2_col0, m_row0_col1, m_row1_col1,
  // m_row2_col1, dphi_first, dphi_second, min_edge_length, face_tag.
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // face_energy, deriv_first, deriv_second, face_tag_out.
  output logic [OUT_W-1:0] out_tdata,
  // below_floor, saturated.
  output logic [1:0]       out_tuser
);

  localparam int T   = FACE_TAG_BITS;
  localparam int DTW = 98;
  localparam int DMW = 97;
  localparam int L   = gnfp_pkg::DIV_LANES;
  localparam int SQ_SIDE_W  = L * DMW + L + 63 + 1 + T;
  localparam int DIV_SIDE_W = 63 + 1 + L + T;

  logic        adv;
  logic [31:0] threshold_r;

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= '0;
    end else if (cfg_wr_en) begin
      threshold_r <= cfg_wr_data;
    end
  end

  // Input unpacking.
  logic signed [31:0] m_in   [3][2];
  logic signed [31:0] dphi_in[2];
  logic [30:0]        edge_len;
  logic [T-1:0]       tag_in;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < 3; i++) begin
        m_in[i][k] = in_tdata[(k*3+i)*32 +: 32];
      end
      dphi_in[k] = in_tdata[192 + k*32 +: 32];
    end
    edge_len = in_tdata[256 +: 31];
    tag_in   = in_tdata[287 +: T];
  end

  // Stage 1: products of M and d, matrix magnitudes, floor.
  logic               v1_r;
  logic signed [63:0] prod1_r [3][2];
  logic [31:0]        mmag1_r [3][2];
  logic               mneg1_r [3][2];
  logic [62:0]        delta1_r;
  logic [T-1:0]       tag1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 2; k++) begin
          prod1_r[i][k] <= m_in[i][k] * dphi_in[k];
          mneg1_r[i][k] <= m_in[i][k][31];
          mmag1_r[i][k] <= m_in[i][k][31] ? (~m_in[i][k] + 32'd1) : m_in[i][k];
        end
      end
      delta1_r <= 63'(edge_len) * 63'(threshold_r);
      tag1_r   <= tag_in;
    end
  end

  // Stage 2: gradient components as sign and magnitude.
  logic         v2_r;
  logic [63:0]  gmag2_r [3];
  logic         gneg2_r [3];
  logic [31:0]  mmag2_r [3][2];
  logic         mneg2_r [3][2];
  logic [62:0]  delta2_r;
  logic [T-1:0] tag2_r;
  logic [64:0]  g_sum [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      g_sum[i] = {prod1_r[i][0][63], prod1_r[i][0]} + {prod1_r[i][1][63], prod1_r[i][1]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        gneg2_r[i] <= g_sum[i][64];
        gmag2_r[i] <= g_sum[i][64] ? (~g_sum[i][63:0] + 64'd1) : g_sum[i][63:0];
      end
      mmag2_r  <= mmag1_r;
      mneg2_r  <= mneg1_r;
      delta2_r <= delta1_r;
      tag2_r   <= tag1_r;
    end
  end

  // Stage 3: partial products of the squares and of the dot products.
  logic         v3_r;
  logic [63:0]  a00_3_r [3];
  logic [63:0]  a01_3_r [3];
  logic [63:0]  a11_3_r [3];
  logic [63:0]  dlo3_r  [3][2];
  logic [63:0]  dhi3_r  [3][2];
  logic         dneg3_r [3][2];
  logic         gz3_r;
  logic [62:0]  delta3_r;
  logic [T-1:0] tag3_r;
  logic         gz;
  logic [63:0]  gd [3];
  logic         gdn [3];

  always_comb begin
    gz = (gmag2_r[0] == '0) && (gmag2_r[1] == '0) && (gmag2_r[2] == '0);
    for (int i = 0; i < 3; i++) begin
      gd[i]  = gz ? 64'h0000_0001_0000_0000 : gmag2_r[i];
      gdn[i] = gz ? 1'b0 : gneg2_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a00_3_r[i] <= 64'(gmag2_r[i][31:0]) * 64'(gmag2_r[i][31:0]);
        a01_3_r[i] <= 64'(gmag2_r[i][31:0]) * 64'(gmag2_r[i][63:32]);
        a11_3_r[i] <= 64'(gmag2_r[i][63:32]) * 64'(gmag2_r[i][63:32]);
        for (int k = 0; k < 2; k++) begin
          dlo3_r[i][k]  <= 64'(gd[i][31:0]) * 64'(mmag2_r[i][k]);
          dhi3_r[i][k]  <= 64'(gd[i][63:32]) * 64'(mmag2_r[i][k]);
          dneg3_r[i][k] <= gdn[i] ^ mneg2_r[i][k];
        end
      end
      gz3_r    <= gz;
      delta3_r <= delta2_r;
      tag3_r   <= tag2_r;
    end
  end

  // Stage 4: squares and signed dot terms.
  logic           v4_r;
  logic [127:0]   sq4_r  [3];
  logic [DTW-1:0] dps4_r [3][2];
  logic           gz4_r;
  logic [62:0]    delta4_r;
  logic [T-1:0]   tag4_r;
  logic [95:0]    dpm [3][2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 2; k++) begin
        dpm[i][k] = {dhi3_r[i][k], 32'd0} + {32'd0, dlo3_r[i][k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq4_r[i] <= {a11_3_r[i], 64'd0} + {31'd0, a01_3_r[i], 33'd0} + {64'd0, a00_3_r[i]};
        for (int k = 0; k < 2; k++) begin
          dps4_r[i][k] <= dneg3_r[i][k] ? (DTW'(0) - {2'b00, dpm[i][k]}) : {2'b00, dpm[i][k]};
        end
      end
      gz4_r    <= gz3_r;
      delta4_r <= delta3_r;
      tag4_r   <= tag3_r;
    end
  end

  // Stage 5: sum of squares and dot products.
  logic           v5_r;
  logic [127:0]   ssum5_r;
  logic [DTW-1:0] dot5_r [2];
  logic           gz5_r;
  logic [62:0]    delta5_r;
  logic [T-1:0]   tag5_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ssum5_r <= sq4_r[0] + sq4_r[1] + sq4_r[2];
      for (int k = 0; k < 2; k++) begin
        dot5_r[k] <= dps4_r[0][k] + dps4_r[1][k] + dps4_r[2][k];
      end
      gz5_r    <= gz4_r;
      delta5_r <= delta4_r;
      tag5_r   <= tag4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // Square root of the squared norm; a zero gradient takes the norm of (1,1,1).
  logic [127:0]          rad;
  logic [DMW-1:0]        dm5 [2];
  logic [1:0]            dn5;
  logic [SQ_SIDE_W-1:0]  sq_side_in;
  logic [SQ_SIDE_W-1:0]  sq_side_out;
  logic                  sq_valid;
  logic [63:0]           sq_root;

  always_comb begin
    rad = gz5_r ? {62'd0, 2'b11, 64'd0} : ssum5_r;
    for (int k = 0; k < 2; k++) begin
      dn5[k] = dot5_r[k][DTW-1];
      dm5[k] = dn5[k] ? DMW'(~dot5_r[k] + DTW'(1)) : dot5_r[k][DMW-1:0];
    end
    sq_side_in = {tag5_r, gz5_r, delta5_r, dn5, dm5[1], dm5[0]};
  end

  gnfp_sqrt #(
    .SIDE_W (SQ_SIDE_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v5_r),
    .in_rad    (rad),
    .in_side   (sq_side_in),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side_out)
  );

  // Floor compare stage.
  logic [DMW-1:0] sq_dm [2];
  logic [1:0]     sq_dn;
  logic [62:0]    sq_delta;
  logic           sq_gz;
  logic [T-1:0]   sq_tag;
  logic [63:0]    np;

  assign {sq_tag, sq_gz, sq_delta, sq_dn, sq_dm[1], sq_dm[0]} = sq_side_out;
  assign np = sq_gz ? 64'd0 : sq_root;

  logic         vf_r;
  logic [62:0]  pf_r;
  logic         belowf_r;
  logic [1:0]   dnf_r;
  logic [127:0] numf_r [L];
  logic [63:0]  denf_r;
  logic [T-1:0] tagf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (adv) begin
      vf_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      belowf_r <= {1'b0, sq_delta} > np;
      pf_r     <= sq_delta - np[62:0];
      dnf_r    <= sq_dn;
      for (int k = 0; k < L; k++) begin
        numf_r[k] <= {1'b0, sq_dm[k], 30'd0};
      end
      denf_r <= sq_root;
      tagf_r <= sq_tag;
    end
  end

  // Quotients |dot| * 2^30 / |g|.
  logic [DIV_SIDE_W-1:0] dv_side_out;
  logic                  dv_valid;
  logic [63:0]           dv_quo [L];

  gnfp_div #(
    .SIDE_W (DIV_SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (vf_r),
    .in_num    (numf_r),
    .in_den    (denf_r),
    .in_side   ({tagf_r, dnf_r, belowf_r, pf_r}),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_side  (dv_side_out)
  );

  logic [62:0]  dv_p;
  logic         dv_below;
  logic [1:0]   dv_dn;
  logic [T-1:0] dv_tag;

  assign {dv_tag, dv_dn, dv_below, dv_p} = dv_side_out;

  // Stage P1: partial products of p*q and p*p.
  logic         vp1_r;
  logic [63:0]  pq00_r [L];
  logic [63:0]  pq01_r [L];
  logic [63:0]  pq10_r [L];
  logic [63:0]  pq11_r [L];
  logic [63:0]  e00_r;
  logic [63:0]  e01_r;
  logic [63:0]  e11_r;
  logic         below1_r;
  logic [1:0]   dnp1_r;
  logic [T-1:0] tagp1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < L; k++) begin
        pq00_r[k] <= 64'(dv_p[31:0]) * 64'(dv_quo[k][31:0]);
        pq01_r[k] <= 64'(dv_p[31:0]) * 64'(dv_quo[k][63:32]);
        pq10_r[k] <= 64'(dv_p[62:32]) * 64'(dv_quo[k][31:0]);
        pq11_r[k] <= 64'(dv_p[62:32]) * 64'(dv_quo[k][63:32]);
      end
      e00_r    <= 64'(dv_p[31:0]) * 64'(dv_p[31:0]);
      e01_r    <= 64'(dv_p[31:0]) * 64'(dv_p[62:32]);
      e11_r    <= 64'(dv_p[62:32]) * 64'(dv_p[62:32]);
      below1_r <= dv_below;
      dnp1_r   <= dv_dn;
      tagp1_r  <= dv_tag;
    end
  end

  // Stage P2: full products.
  logic         vp2_r;
  logic [127:0] pq2_r [L];
  logic [127:0] psq2_r;
  logic         below2_r;
  logic [1:0]   dnp2_r;
  logic [T-1:0] tagp2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < L; k++) begin
        pq2_r[k] <= {pq11_r[k], 64'd0} + {32'd0, pq10_r[k], 32'd0}
                  + {32'd0, pq01_r[k], 32'd0} + {64'd0, pq00_r[k]};
      end
      psq2_r   <= {e11_r, 64'd0} + {31'd0, e01_r, 33'd0} + {64'd0, e00_r};
      below2_r <= dnp1_r == dnp1_r ? below1_r : below1_r;
      dnp2_r   <= dnp1_r;
      tagp2_r  <= tagp1_r;
    end
  end

  // Stage P3: scaling, clamping and the output register.
  logic [82:0] mag  [L];
  logic [95:0] eraw;
  logic [63:0] der  [L];
  logic [L-1:0] dsat;
  logic [62:0] energy;
  logic        esat;

  always_comb begin
    eraw   = psq2_r[127:32];
    esat   = eraw[95:63] != '0;
    energy = esat ? {63{1'b1}} : eraw[62:0];
    for (int k = 0; k < L; k++) begin
      mag[k] = pq2_r[k][127:45];
      if (!dnp2_r[k] && (mag[k] != '0)) begin
        dsat[k] = (mag[k][82:64] != '0) || (mag[k][63] && (mag[k][62:0] != '0));
        der[k]  = dsat[k] ? 64'h8000_0000_0000_0000 : (~mag[k][63:0] + 64'd1);
      end else begin
        dsat[k] = mag[k][82:63] != '0;
        der[k]  = dsat[k] ? 64'h7fff_ffff_ffff_ffff : {1'b0, mag[k][62:0]};
      end
    end
  end

  logic         vo_r;
  logic [62:0]  energy_r;
  logic [63:0]  der_r [L];
  logic         below_r;
  logic         sat_r;
  logic [T-1:0] tago_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      energy_r <= below2_r ? energy : '0;
      for (int k = 0; k < L; k++) begin
        der_r[k] <= below2_r ? der[k] : '0;
      end
      below_r <= below2_r;
      sat_r   <= below2_r && (esat || (dsat != '0));
      tago_r  <= tagp2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp1_r <= 1'b0;
      vp2_r <= 1'b0;
      vo_r  <= 1'b0;
    end else if (adv) begin
      vp1_r <= dv_valid;
      vp2_r <= vp1_r;
      vo_r  <= vp2_r;
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = OUT_W'({tago_r, der_r[1], der_r[0], energy_r});
  assign out_tuser  = {sat_r, below_r};

  a_above_floor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> (out_tdata[190:0] == '0) && !out_tuser[1])
    else $error("nonzero result for a face above the floor");

  a_sat_needs_below: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0])
    else $error("saturation flagged on a face above the floor");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while the output register is empty");

endmodule
